/* src/slpc_pkg.sv */
// slpc_pkg: shared types and constants of the status led pattern controller
// state and operation codes, configuration index codes, led masks, pattern bounds, config and state records
// no dependencies
package slpc_pkg;

	typedef enum logic [3:0] {
		ST_STARTING     = 4'd0,
		ST_CONNECTING   = 4'd1,
		ST_CONNECTED    = 4'd2,
		ST_AP_MODE      = 4'd3,
		ST_READY        = 4'd4,
		ST_RUNNING      = 4'd5,
		ST_PAUSED       = 4'd6,
		ST_SYNC_WAIT    = 4'd7,
		ST_ERROR        = 4'd8,
		ST_DISCONNECTED = 4'd9,
		ST_CRITICAL     = 4'd10
	} mode_t;

	typedef enum logic [2:0] {
		OP_TICK        = 3'd0,
		OP_SET_STATE   = 3'd1,
		OP_RUNNING     = 3'd2,
		OP_SYNC_WAIT   = 3'd3,
		OP_CONN_LOST   = 3'd4,
		OP_RAISE_ERROR = 3'd5,
		OP_CLEAR_ERROR = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		CFG_ERROR_LIMIT  = 3'd0,
		CFG_SETTLE_MS    = 3'd1,
		CFG_CONNECTING   = 3'd2,
		CFG_RUNNING      = 3'd3,
		CFG_DISCONNECTED = 3'd4,
		CFG_SLOW         = 3'd5,
		CFG_RAPID        = 3'd6
	} cfg_idx_t;

	localparam logic [2:0] LED_OFF = 3'b000;
	localparam logic [2:0] LED_G   = 3'b001;
	localparam logic [2:0] LED_Y   = 3'b010;
	localparam logic [2:0] LED_R   = 3'b100;

	localparam logic [15:0] TIME_MAX  = 16'hFFFF;
	localparam logic [7:0]  ERROR_MAX = 8'hFF;

	localparam logic [15:0] START_RED_END    = 16'd100;
	localparam logic [15:0] START_YELLOW_END = 16'd200;
	localparam logic [15:0] START_GREEN_END  = 16'd300;
	localparam logic [15:0] START_CYCLE_END  = 16'd700;
	localparam logic [15:0] ERR_RED1_END     = 16'd150;
	localparam logic [15:0] ERR_OFF1_END     = 16'd300;
	localparam logic [15:0] ERR_RED2_END     = 16'd450;
	localparam logic [15:0] ERR_CYCLE_END    = 16'd1000;

	typedef struct packed {
		logic [7:0]  error_limit;
		logic [15:0] settle_ms;
		logic [15:0] connecting_period;
		logic [15:0] running_period;
		logic [15:0] disconnected_period;
		logic [15:0] slow_period;
		logic [15:0] rapid_period;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic        phase;
		logic [15:0] since_blink;
		logic [15:0] since_change;
		logic        stable;
		logic [7:0]  errors;
		logic [2:0]  leds;
	} status_t;

endpackage

/* src/status_led_pattern_controller_top.sv */
// status_led_pattern_controller_top: event-driven status led controller, top level
// input register, single-pass update core and result register
// depends on slpc_pkg, slpc_cfg, slpc_core
//
// Each event (tick, state set, running, sync wait, connection lost, raise error,
// clear errors) yields one result with the three leds, the state, the stable flag
// and the error count after that event. An event passes from input transfer to
// result through the input register, where the whole state update is done in
// one pass, and then the result register. One event is taken per cycle
// while the result side keeps up; the input register refills while a result waits.
// Configuration writes are taken at any time, one per cycle.
module status_led_pattern_controller_top import slpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [3:0]  new_state,
	input  logic        flag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        led_green,
	output logic        led_yellow,
	output logic        led_red,
	output logic [3:0]  state_code,
	output logic        settled,
	output logic [7:0]  errors
);

	cfg_t       cfg;
	status_t    nxt;
	logic       valid_s1;
	logic [2:0] op_s1;
	logic [3:0] target_s1;
	logic       flag_s1;
	logic       out_valid_q;
	status_t    res_q;
	logic       advance;

	slpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	slpc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (valid_s1 && advance),
		.op     (op_t'(op_s1)),
		.target (target_s1),
		.flag   (flag_s1),
		.cfg    (cfg),
		.nxt    (nxt)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1     <= operation;
			target_s1 <= new_state;
			flag_s1   <= flag;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance)
			res_q <= nxt;
	end

	assign out_valid  = out_valid_q;
	assign led_green  = res_q.leds[0];
	assign led_yellow = res_q.leds[1];
	assign led_red    = res_q.leds[2];
	assign state_code = res_q.mode;
	assign settled    = res_q.stable;
	assign errors     = res_q.errors;

endmodule

/* src/slpc_cfg.sv */
// slpc_cfg: configuration register file of the status led pattern controller
// takes one register write per transfer on the config channel
// depends on slpc_pkg
module slpc_cfg import slpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.error_limit         <= 8'd5;
			cfg_q.settle_ms           <= 16'd2000;
			cfg_q.connecting_period   <= 16'd500;
			cfg_q.running_period      <= 16'd250;
			cfg_q.disconnected_period <= 16'd300;
			cfg_q.slow_period         <= 16'd1000;
			cfg_q.rapid_period        <= 16'd150;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ERROR_LIMIT:  cfg_q.error_limit         <= cfg_data[7:0];
				CFG_SETTLE_MS:    cfg_q.settle_ms           <= cfg_data;
				CFG_CONNECTING:   cfg_q.connecting_period   <= cfg_data;
				CFG_RUNNING:      cfg_q.running_period      <= cfg_data;
				CFG_DISCONNECTED: cfg_q.disconnected_period <= cfg_data;
				CFG_SLOW:         cfg_q.slow_period         <= cfg_data;
				CFG_RAPID:        cfg_q.rapid_period        <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

/* src/slpc_core.sv */
// slpc_core: state registers and single-pass event update of the controller
// computes the next state and led pattern for one event from the stage 1 item
// depends on slpc_pkg
module slpc_core import slpc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  op_t        op,
	input  logic [3:0] target,
	input  logic       flag,
	input  cfg_t       cfg,
	output status_t    nxt
);

	status_t st_q;

	function automatic status_t bump(status_t s);
		status_t r;
		r = s;
		if (s.errors != ERROR_MAX)
			r.errors = s.errors + 8'd1;
		return r;
	endfunction

	function automatic status_t enter(status_t s, mode_t t);
		status_t r;
		r = s;
		if (t != s.mode) begin
			r.mode         = t;
			r.since_change = '0;
			r.stable       = 1'b0;
			r.leds         = LED_OFF;
			if (t == ST_CONNECTED || t == ST_READY) begin
				r.leds   = LED_G;
				r.stable = 1'b1;
			end else if (t == ST_AP_MODE) begin
				r.leds   = LED_Y;
				r.stable = 1'b1;
			end else if (t == ST_ERROR) begin
				r = bump(r);
			end
		end
		return r;
	endfunction

	function automatic status_t blink(status_t s, logic [15:0] period, logic [2:0] on_leds);
		status_t r;
		r = s;
		if (s.since_blink > period) begin
			r.phase       = ~s.phase;
			r.since_blink = '0;
		end
		r.leds = r.phase ? on_leds : LED_OFF;
		return r;
	endfunction

	function automatic status_t tick(status_t s, cfg_t c);
		status_t     r;
		logic [15:0] e;
		r = s;
		if (s.since_blink != TIME_MAX)
			r.since_blink = s.since_blink + 16'd1;
		if (s.since_change != TIME_MAX)
			r.since_change = s.since_change + 16'd1;
		e = r.since_blink;
		case (s.mode)
			ST_STARTING: begin
				if (e < START_RED_END) r.leds = LED_R;
				else if (e < START_YELLOW_END) r.leds = LED_Y;
				else if (e < START_GREEN_END) r.leds = LED_G;
				else if (e < START_CYCLE_END) r.leds = LED_OFF;
				else r.since_blink = '0;
			end
			ST_CONNECTING:   r = blink(r, c.connecting_period, LED_Y);
			ST_RUNNING:      r = blink(r, c.running_period, LED_G);
			ST_PAUSED:       r = blink(r, c.slow_period, LED_Y);
			ST_SYNC_WAIT:    r = blink(r, c.rapid_period, LED_G | LED_Y);
			ST_DISCONNECTED: r = blink(r, c.disconnected_period, LED_R);
			ST_ERROR: begin
				if (e < ERR_RED1_END) r.leds = LED_R;
				else if (e < ERR_OFF1_END) r.leds = LED_OFF;
				else if (e < ERR_RED2_END) r.leds = LED_R;
				else if (e < ERR_CYCLE_END) r.leds = LED_OFF;
				else r.since_blink = '0;
			end
			ST_CRITICAL:     r = blink(r, c.rapid_period, LED_R | LED_Y);
			default: ;
		endcase
		if (!r.stable && r.since_change > c.settle_ms)
			r.stable = 1'b1;
		return r;
	endfunction

	status_t raised;

	always_comb begin
		raised = bump(st_q);
		nxt    = st_q;
		case (op)
			OP_TICK: nxt = tick(st_q, cfg);
			OP_SET_STATE: begin
				if (target <= ST_CRITICAL)
					nxt = enter(st_q, mode_t'(target));
			end
			OP_RUNNING: begin
				if (flag && st_q.mode == ST_READY)
					nxt = enter(st_q, ST_RUNNING);
				else if (!flag && st_q.mode == ST_RUNNING)
					nxt = enter(st_q, ST_READY);
			end
			OP_SYNC_WAIT: begin
				if (flag)
					nxt = enter(st_q, ST_SYNC_WAIT);
				else if (st_q.mode == ST_SYNC_WAIT)
					nxt = enter(st_q, ST_READY);
			end
			OP_CONN_LOST: begin
				if (flag)
					nxt = enter(st_q, ST_DISCONNECTED);
				else if (st_q.mode == ST_DISCONNECTED)
					nxt = enter(st_q, ST_CONNECTED);
			end
			OP_RAISE_ERROR: begin
				if (raised.errors >= cfg.error_limit)
					nxt = enter(raised, ST_CRITICAL);
				else
					nxt = enter(raised, ST_ERROR);
			end
			OP_CLEAR_ERROR: begin
				nxt        = st_q;
				nxt.errors = '0;
				if (st_q.mode == ST_ERROR || st_q.mode == ST_CRITICAL)
					nxt = enter(nxt, ST_READY);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode         <= ST_STARTING;
			st_q.phase        <= 1'b0;
			st_q.since_blink  <= '0;
			st_q.since_change <= '0;
			st_q.stable       <= 1'b1;
			st_q.errors       <= '0;
			st_q.leds         <= LED_OFF;
		end else if (en) begin
			st_q <= nxt;
		end
	end

endmodule
